// ----- sv/rtsr_pkg.sv -----
// Shared constants, codes and types of the right triangle side resolver.
`default_nettype none
package rtsr_pkg;
   localparam int SideWidth = 16;
   localparam int FracBits  = 8;

   localparam int MagOutW  = SideWidth + FracBits;
   localparam int SgnOutW  = MagOutW + 1;
   localparam int SqW      = 2 * SideWidth;
   localparam int RootBits = MagOutW;
   localparam int RadW     = 2 * RootBits;
   localparam int RemW     = RootBits + 3;
   localparam int ReqDataW = ((3 * SideWidth + 3 + 7) / 8) * 8;
   localparam int RspDataW = ((MagOutW + 2 * SgnOutW + 7) / 8) * 8;

   localparam logic [1:0] OpOppHyp = 2'd0;
   localparam logic [1:0] OpAdjHyp = 2'd1;
   localparam logic [1:0] OpOppAdj = 2'd2;

   localparam logic [1:0] ErrNone     = 2'd0;
   localparam logic [1:0] ErrNegHyp   = 2'd1;
   localparam logic [1:0] ErrLegLong  = 2'd2;
   localparam logic [1:0] ErrQuadrant = 2'd3;

   localparam logic [1:0] SelAdj = 2'd0;
   localparam logic [1:0] SelOpp = 2'd1;
   localparam logic [1:0] SelHyp = 2'd2;

   localparam logic [2:0] Quad1 = 3'd1;
   localparam logic [2:0] Quad2 = 3'd2;
   localparam logic [2:0] Quad3 = 3'd3;
   localparam logic [2:0] Quad4 = 3'd4;

   typedef struct packed {
      logic [1:0]           err;
      logic [1:0]           root_sel;
      logic                 opp_neg;
      logic                 adj_neg;
      logic [SideWidth-1:0] opp_mag;
      logic [SideWidth-1:0] adj_mag;
      logic [SideWidth-1:0] hyp_mag;
   } side_type;

   typedef struct packed {
      logic [RemW-1:0]     rem;
      logic [RootBits-1:0] root;
      logic [RadW-1:0]     rad;
   } root_type;
endpackage
`default_nettype wire

// ----- sv/rtsr_front.sv -----
// Front stages: decode and error checks, squaring, radicand forming.
`default_nettype none
module rtsr_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [1:0]                          opcode,
   input  wire logic signed [rtsr_pkg::SideWidth-1:0] opposite_in,
   input  wire logic signed [rtsr_pkg::SideWidth-1:0] adjacent_in,
   input  wire logic signed [rtsr_pkg::SideWidth-1:0] hypotenuse_in,
   input  wire logic [2:0]                          quadrant,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output rtsr_pkg::side_type                       out_side,
   output rtsr_pkg::root_type                       out_root
);
   localparam int Sw = rtsr_pkg::SideWidth;

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;

   logic [Sw-1:0] om, am, hm, leg;
   logic          on, an, hn, q_ok, q23, q34;

   rtsr_pkg::side_type side1_in, side1_ff, side2_ff, side3_ff;
   logic [Sw-1:0] x1_in, x1_ff, y1_in, y1_ff;
   logic          sub1_in, sub1_ff, sub2_ff;
   logic [rtsr_pkg::SqW-1:0] sx2_in, sx2_ff, sy2_in, sy2_ff;
   logic [rtsr_pkg::RadW-1:0] rad3_in, rad3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      on   = opposite_in[Sw-1];
      an   = adjacent_in[Sw-1];
      hn   = hypotenuse_in[Sw-1];
      om   = on ? (~opposite_in) + Sw'(1) : opposite_in;
      am   = an ? (~adjacent_in) + Sw'(1) : adjacent_in;
      hm   = hn ? (~hypotenuse_in) + Sw'(1) : hypotenuse_in;
      leg  = (opcode == rtsr_pkg::OpOppHyp) ? om : am;
      q_ok = (quadrant == rtsr_pkg::Quad1) || (quadrant == rtsr_pkg::Quad2) ||
             (quadrant == rtsr_pkg::Quad3) || (quadrant == rtsr_pkg::Quad4);
      q23  = (quadrant == rtsr_pkg::Quad2) || (quadrant == rtsr_pkg::Quad3);
      q34  = (quadrant == rtsr_pkg::Quad3) || (quadrant == rtsr_pkg::Quad4);

      side1_in.opp_mag  = om;
      side1_in.adj_mag  = am;
      side1_in.hyp_mag  = hm;
      side1_in.opp_neg  = on || ((om != '0) && q34);
      side1_in.adj_neg  = an || ((am != '0) && q23);
      side1_in.root_sel = rtsr_pkg::SelHyp;
      side1_in.err      = rtsr_pkg::ErrNone;
      x1_in             = hm;
      y1_in             = leg;
      sub1_in           = 1'b1;

      unique case (opcode)
         rtsr_pkg::OpOppHyp, rtsr_pkg::OpAdjHyp: begin
            if (hn) side1_in.err = rtsr_pkg::ErrNegHyp;
            else if (leg > hm) side1_in.err = rtsr_pkg::ErrLegLong;
            else if (!q_ok) side1_in.err = rtsr_pkg::ErrQuadrant;
            if (opcode == rtsr_pkg::OpOppHyp) begin
               side1_in.root_sel = rtsr_pkg::SelAdj;
               side1_in.adj_neg  = q23;
            end else begin
               side1_in.root_sel = rtsr_pkg::SelOpp;
               side1_in.opp_neg  = q34;
            end
         end
         rtsr_pkg::OpOppAdj: begin
            if (!q_ok) side1_in.err = rtsr_pkg::ErrQuadrant;
            x1_in   = om;
            y1_in   = am;
            sub1_in = 1'b0;
         end
         default: side1_in.err = rtsr_pkg::ErrQuadrant;
      endcase
   end

   assign sx2_in = rtsr_pkg::SqW'(x1_ff) * rtsr_pkg::SqW'(x1_ff);
   assign sy2_in = rtsr_pkg::SqW'(y1_ff) * rtsr_pkg::SqW'(y1_ff);
   // leg above hypotenuse underflows here, but that item is flagged and zeroed
   assign rad3_in = rtsr_pkg::RadW'(sub2_ff ? sx2_ff - sy2_ff : sx2_ff + sy2_ff)
                    << (2 * rtsr_pkg::FracBits);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         side1_ff <= side1_in;
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         sub1_ff  <= sub1_in;
      end
      if (rdy2 && v1_ff) begin
         side2_ff <= side1_ff;
         sx2_ff   <= sx2_in;
         sy2_ff   <= sy2_in;
         sub2_ff  <= sub1_ff;
      end
      if (rdy3 && v2_ff) begin
         side3_ff <= side2_ff;
         rad3_ff  <= rad3_in;
      end
   end

   assign out_valid     = v3_ff;
   assign out_side      = side3_ff;
   assign out_root.rem  = '0;
   assign out_root.root = '0;
   assign out_root.rad  = rad3_ff;
endmodule
`default_nettype wire

// ----- sv/rtsr_root_step.sv -----
// One registered restoring square root step: one result bit per stage.
`default_nettype none
module rtsr_root_step (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire rtsr_pkg::side_type in_side,
   input  wire rtsr_pkg::root_type in_root,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rtsr_pkg::side_type out_side,
   output rtsr_pkg::root_type out_root
);
   localparam int Rb = rtsr_pkg::RootBits;
   localparam int Rw = rtsr_pkg::RemW;

   logic                valid_ff;
   rtsr_pkg::side_type  side_ff;
   rtsr_pkg::root_type  root_in, root_ff;
   logic [Rw-1:0]       rem_sh, trial;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rem_sh      = {in_root.rem[Rw-3:0], in_root.rad[rtsr_pkg::RadW-1 -: 2]};
      trial       = Rw'({in_root.root, 2'b01});
      root_in.rad = in_root.rad << 2;
      if (rem_sh >= trial) begin
         root_in.rem  = rem_sh - trial;
         root_in.root = {in_root.root[Rb-2:0], 1'b1};
      end else begin
         root_in.rem  = rem_sh;
         root_in.root = {in_root.root[Rb-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_root  = root_ff;
endmodule
`default_nettype wire

// ----- sv/rtsr_back.sv -----
// Output stage: picks root or given sides, applies signs and errors, holds the response.
`default_nettype none
module rtsr_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire rtsr_pkg::side_type            in_side,
   input  wire logic [rtsr_pkg::RootBits-1:0] in_root,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [rtsr_pkg::RspDataW-1:0]      rsp_tdata,
   output logic [1:0]                         rsp_tuser
);
   localparam int Mw = rtsr_pkg::MagOutW;
   localparam int Gw = rtsr_pkg::SgnOutW;

   logic                         valid_ff;
   logic [rtsr_pkg::RspDataW-1:0] data_in, data_ff;
   logic [1:0]                   user_in, user_ff;
   logic [Mw-1:0]                hyp, opp_mag, adj_mag;
   logic [Gw-1:0]                opp, adj;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      hyp     = Mw'(in_side.hyp_mag) << rtsr_pkg::FracBits;
      opp_mag = Mw'(in_side.opp_mag) << rtsr_pkg::FracBits;
      adj_mag = Mw'(in_side.adj_mag) << rtsr_pkg::FracBits;
      unique case (in_side.root_sel)
         rtsr_pkg::SelAdj: adj_mag = Mw'(in_root);
         rtsr_pkg::SelOpp: opp_mag = Mw'(in_root);
         default:          hyp     = Mw'(in_root);
      endcase
      opp = in_side.opp_neg ? Gw'(0) - Gw'(opp_mag) : Gw'(opp_mag);
      adj = in_side.adj_neg ? Gw'(0) - Gw'(adj_mag) : Gw'(adj_mag);
      if (in_side.err != rtsr_pkg::ErrNone) begin
         hyp = '0;
         opp = '0;
         adj = '0;
      end
      data_in = rtsr_pkg::RspDataW'({adj, opp, hyp});
      user_in = in_side.err;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
endmodule
`default_nettype wire

// ----- sv/right_triangle_side_resolver.sv -----
// Right triangle side resolver: finds the missing side of a right triangle and signs
// the legs by quadrant. One request is taken per clock cycle while the pipeline is not
// stalled; each passes the front stages (decode, squaring, radicand), the square root
// steps, which yield one result bit per pipeline stage, and the output stage. Every
// stage stalls only when the one after it is full, so bubbles close up under back
// pressure. Error codes: 1 negative hypotenuse, 2 leg longer than the hypotenuse, 3 bad
// quadrant or unused opcode; on any error the sides read zero.
`default_nettype none
module right_triangle_side_resolver (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // opposite_in, adjacent_in, hypotenuse_in, quadrant, zero fill
   input  wire logic [rtsr_pkg::ReqDataW-1:0] req_tdata,
   // opcode
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // hypotenuse_out, opposite_out, adjacent_out, zero fill
   output logic [rtsr_pkg::RspDataW-1:0]      rsp_tdata,
   // error_code
   output logic [1:0]                         rsp_tuser
);
   localparam int Sw = rtsr_pkg::SideWidth;
   localparam int Rb = rtsr_pkg::RootBits;

   logic               link_valid [Rb+1];
   logic               link_ready [Rb+1];
   rtsr_pkg::side_type link_side  [Rb+1];
   rtsr_pkg::root_type link_root  [Rb+1];

   rtsr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .opcode        (req_tuser),
      .opposite_in   (req_tdata[Sw-1:0]),
      .adjacent_in   (req_tdata[2*Sw-1:Sw]),
      .hypotenuse_in (req_tdata[3*Sw-1:2*Sw]),
      .quadrant      (req_tdata[3*Sw+2:3*Sw]),
      .out_valid     (link_valid[0]),
      .out_ready     (link_ready[0]),
      .out_side      (link_side[0]),
      .out_root      (link_root[0])
   );

   for (genvar g = 0; g < Rb; g++) begin : g_root
      rtsr_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_side   (link_side[g]),
         .in_root   (link_root[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_side  (link_side[g+1]),
         .out_root  (link_root[g+1])
      );
   end

   rtsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[Rb]),
      .in_ready   (link_ready[Rb]),
      .in_side    (link_side[Rb]),
      .in_root    (link_root[Rb].root),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
`default_nettype wire

// ----- tb/sv/tb_right_triangle_side_resolver.sv -----
// Testbench for the right triangle side resolver: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module tb_right_triangle_side_resolver;
   localparam int SW        = rtsr_pkg::SideWidth;
   localparam int FB        = rtsr_pkg::FracBits;
   localparam int MW        = rtsr_pkg::MagOutW;
   localparam int GW        = rtsr_pkg::SgnOutW;
   localparam int RandCount = 1900;
   localparam int StallMax  = 2000;

   typedef struct packed {
      logic [1:0]    err;
      logic [GW-1:0] adj;
      logic [GW-1:0] opp;
      logic [MW-1:0] hyp;
   } side_result_t;

   class triangle_scoreboard;
      side_result_t expected_q[$];
      int           failures = 0;

      function longint unsigned fixed_root(longint unsigned v);
         longint unsigned root;
         longint unsigned rem;
         longint unsigned pair;
         longint unsigned trial;
         root = 0;
         rem  = 0;
         for (int i = 31 + FB; i >= 0; i--) begin
            pair  = (i >= FB) ? ((v >> (2 * (i - FB))) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function side_result_t resolve_sides(logic [1:0] op, logic [rtsr_pkg::ReqDataW-1:0] data);
         logic [SW-1:0]   o_raw, a_raw, h_raw;
         logic [2:0]      q;
         logic            o_neg, a_neg, h_neg, q_ok, q_opp_neg, q_adj_neg, opp_neg, adj_neg;
         longint unsigned om, am, hm, leg, hyp, opp, adj, root;
         logic [1:0]      err;
         side_result_t    res;
         o_raw     = data[SW-1:0];
         a_raw     = data[2*SW-1:SW];
         h_raw     = data[3*SW-1:2*SW];
         q         = data[3*SW+2:3*SW];
         o_neg     = o_raw[SW-1];
         a_neg     = a_raw[SW-1];
         h_neg     = h_raw[SW-1];
         om        = o_neg ? SW'(-o_raw) : o_raw;
         am        = a_neg ? SW'(-a_raw) : a_raw;
         hm        = h_neg ? SW'(-h_raw) : h_raw;
         q_ok      = (q >= rtsr_pkg::Quad1) && (q <= rtsr_pkg::Quad4);
         q_opp_neg = (q == rtsr_pkg::Quad3) || (q == rtsr_pkg::Quad4);
         q_adj_neg = (q == rtsr_pkg::Quad2) || (q == rtsr_pkg::Quad3);
         err       = rtsr_pkg::ErrNone;
         hyp       = 0;
         opp       = 0;
         adj       = 0;
         opp_neg   = 1'b0;
         adj_neg   = 1'b0;
         unique case (op)
            rtsr_pkg::OpOppHyp, rtsr_pkg::OpAdjHyp: begin
               leg = (op == rtsr_pkg::OpOppHyp) ? om : am;
               if (h_neg) begin
                  err = rtsr_pkg::ErrNegHyp;
               end else if (leg > hm) begin
                  err = rtsr_pkg::ErrLegLong;
               end else if (!q_ok) begin
                  err = rtsr_pkg::ErrQuadrant;
               end else begin
                  root = fixed_root(hm * hm - leg * leg);
                  hyp  = hm << FB;
                  if (op == rtsr_pkg::OpOppHyp) begin
                     opp     = om << FB;
                     opp_neg = o_neg || (om != 0 && q_opp_neg);
                     adj     = root;
                     adj_neg = q_adj_neg;
                  end else begin
                     adj     = am << FB;
                     adj_neg = a_neg || (am != 0 && q_adj_neg);
                     opp     = root;
                     opp_neg = q_opp_neg;
                  end
               end
            end
            rtsr_pkg::OpOppAdj: begin
               if (!q_ok) begin
                  err = rtsr_pkg::ErrQuadrant;
               end else begin
                  hyp     = fixed_root(om * om + am * am);
                  opp     = om << FB;
                  opp_neg = o_neg || (om != 0 && q_opp_neg);
                  adj     = am << FB;
                  adj_neg = a_neg || (am != 0 && q_adj_neg);
               end
            end
            default: begin
               err = rtsr_pkg::ErrQuadrant;
            end
         endcase
         if (err != rtsr_pkg::ErrNone) begin
            hyp     = 0;
            opp     = 0;
            adj     = 0;
            opp_neg = 1'b0;
            adj_neg = 1'b0;
         end
         res.err = err;
         res.hyp = MW'(hyp);
         res.opp = opp_neg ? GW'(64'd0 - opp) : GW'(opp);
         res.adj = adj_neg ? GW'(64'd0 - adj) : GW'(adj);
         return res;
      endfunction

      function void note_request(logic [1:0] op, logic [rtsr_pkg::ReqDataW-1:0] data);
         expected_q.push_back(resolve_sides(op, data));
      endfunction

      function void compare_field(string name, logic [GW-1:0] want, logic [GW-1:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [rtsr_pkg::RspDataW-1:0] data, logic [1:0] user);
         side_result_t want;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none actual %h/%h", $time, data, user);
            return;
         end
         want = expected_q.pop_front();
         compare_field("hypotenuse", GW'(want.hyp), GW'(data[MW-1:0]));
         compare_field("opposite", want.opp, data[MW+GW-1:MW]);
         compare_field("adjacent", want.adj, data[MW+2*GW-1:MW+GW]);
         compare_field("error", GW'(want.err), GW'(user));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [rtsr_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic [1:0]                    req_tuser  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [rtsr_pkg::RspDataW-1:0] rsp_tdata;
   logic [1:0]                    rsp_tuser;

   triangle_scoreboard sides_sb   = new();
   int                 phase      = 0;
   int                 idle_count = 0;

   right_triangle_side_resolver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // response side: check, watchdog, random back pressure
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         sides_sb.check_response(rsp_tdata, rsp_tuser);
      end
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
         idle_count <= 0;
      end else if (idle_count >= StallMax) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
      rsp_tready <= $urandom_range(99) >= ((phase == 0) ? 47 : (phase == 1) ? 24 : 0);
   end

   task automatic send_request(input logic [1:0] op, input logic [SW-1:0] o,
                               input logic [SW-1:0] a, input logic [SW-1:0] h,
                               input logic [2:0] q);
      logic [rtsr_pkg::ReqDataW-1:0] data;
      int                            pct;
      data = '0;
      data[SW-1:0]      = o;
      data[2*SW-1:SW]   = a;
      data[3*SW-1:2*SW] = h;
      data[3*SW+2:3*SW] = q;
      pct = (phase == 0) ? 24 : (phase == 1) ? 47 : 0;
      while ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sides_sb.note_request(op, data);
   endtask

   initial begin
      int            total;
      int            mag;
      int            h;
      logic [1:0]    op;
      logic [SW-1:0] leg;
      total = 24 + RandCount;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, sign rules, error order
      send_request(rtsr_pkg::OpOppHyp, 16'sd3, 16'sd1234, 16'sd5, rtsr_pkg::Quad1);
      send_request(rtsr_pkg::OpAdjHyp, 16'sd4321, 16'sd4, 16'sd5, rtsr_pkg::Quad2);
      send_request(rtsr_pkg::OpOppAdj, 16'sd3, 16'sd4, -16'sd77, rtsr_pkg::Quad3);
      send_request(2'd3, 16'sd3, 16'sd4, 16'sd5, rtsr_pkg::Quad1);
      send_request(rtsr_pkg::OpOppHyp, 16'sd32767, 16'sd0, 16'sd32767, rtsr_pkg::Quad4);
      send_request(rtsr_pkg::OpOppHyp, 16'sd0, 16'sd0, 16'sd32767, rtsr_pkg::Quad3);
      send_request(rtsr_pkg::OpOppHyp, -16'sd32768, 16'sd0, 16'sd32767, rtsr_pkg::Quad1);
      send_request(rtsr_pkg::OpAdjHyp, 16'sd0, -16'sd32767, 16'sd32767, rtsr_pkg::Quad2);
      send_request(rtsr_pkg::OpOppHyp, 16'sd1, 16'sd0, -16'sd1, rtsr_pkg::Quad1);
      send_request(rtsr_pkg::OpAdjHyp, 16'sd0, 16'sd0, -16'sd32768, 3'd0);
      send_request(rtsr_pkg::OpOppHyp, 16'sd9, 16'sd0, 16'sd8, 3'd7);
      send_request(rtsr_pkg::OpOppHyp, 16'sd0, 16'sd0, 16'sd0, rtsr_pkg::Quad2);
      send_request(rtsr_pkg::OpOppHyp, 16'sd5, 16'sd0, 16'sd13, 3'd0);
      send_request(rtsr_pkg::OpAdjHyp, 16'sd0, 16'sd12, 16'sd13, 3'd5);
      send_request(rtsr_pkg::OpOppAdj, 16'sd3, 16'sd4, 16'sd0, 3'd6);
      send_request(rtsr_pkg::OpOppAdj, -16'sd32768, -16'sd32768, 16'sd0, rtsr_pkg::Quad1);
      send_request(rtsr_pkg::OpOppAdj, 16'sd32767, 16'sd32767, 16'sd0, rtsr_pkg::Quad2);
      send_request(rtsr_pkg::OpOppAdj, 16'sd0, 16'sd0, 16'sd0, rtsr_pkg::Quad4);
      send_request(rtsr_pkg::OpOppAdj, -16'sd7, 16'sd24, 16'sd0, rtsr_pkg::Quad3);
      send_request(rtsr_pkg::OpOppAdj, 16'sd7, -16'sd24, 16'sd0, rtsr_pkg::Quad4);
      send_request(rtsr_pkg::OpOppHyp, -16'sd5, 16'sd0, 16'sd13, rtsr_pkg::Quad3);
      send_request(rtsr_pkg::OpAdjHyp, 16'sd0, 16'sd12, 16'sd13, rtsr_pkg::Quad3);
      send_request(rtsr_pkg::OpOppHyp, 16'sd1, 16'sd0, 16'sd2, rtsr_pkg::Quad4);
      send_request(2'd3, -16'sd1, -16'sd1, -16'sd1, 3'd7);

      for (int n = 0; n < RandCount; n++) begin
         phase = ((n + 24) * 3) / total;
         if ($urandom_range(99) < 80) begin
            op = 2'($urandom_range(2));
            h  = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(32767);
            if (op == rtsr_pkg::OpOppAdj) begin
               send_request(op, SW'($urandom), SW'($urandom), SW'($urandom),
                            3'($urandom_range(1, 4)));
            end else begin
               mag = ($urandom_range(9) == 0 && h < 32767) ? h + 1 : $urandom_range(h);
               leg = $urandom_range(1) ? SW'(-mag) : SW'(mag);
               if (op == rtsr_pkg::OpOppHyp) begin
                  send_request(op, leg, SW'($urandom), SW'(h), 3'($urandom_range(1, 4)));
               end else begin
                  send_request(op, SW'($urandom), leg, SW'(h), 3'($urandom_range(1, 4)));
               end
            end
         end else begin
            send_request(2'($urandom_range(3)), SW'($urandom), SW'($urandom), SW'($urandom),
                         3'($urandom_range(7)));
         end
      end
      req_tvalid <= 1'b0;

      while (sides_sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sides_sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
